// ===== hw/rtl/pts_pkg.sv =====
// Shared types, constants and request codes of the priority thread scheduler.
package pts_pkg;

    localparam int MAX_THREADS_DEF = 16;
    localparam int NUM_MUTEXES_DEF = 4;
    localparam int NUM_LEVELS      = 3;

    localparam int REQ_W    = 3;
    localparam int PRIO_W   = 2;
    localparam int TID_W    = 4;
    localparam int MUTEX_W  = 2;

    localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_YIELD  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WAIT   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_EXIT   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_MINIT  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_LOCK   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNLOCK = 3'd6;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [PRIO_W-1:0]  prio;
        logic [TID_W-1:0]   target_tid;
        logic [MUTEX_W-1:0] mutex_id;
    } req_t;

    typedef struct packed {
        logic             status;
        logic [TID_W-1:0] new_tid;
        logic [TID_W-1:0] running_tid;
        logic             running_valid;
        logic             switched;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request
        logic exec;      // execute request body
        logic disp;      // one dispatch step
        logic finish;    // form response
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_disp; // request ends with a dispatch
        logic disp_done; // dispatch settled
    } sts_t;

endpackage

// ===== hw/rtl/pts_ctrl.sv =====
// Request sequencer of the priority thread scheduler.
module pts_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output pts_pkg::cmd_t cmd,
    input  pts_pkg::sts_t sts
);
    import pts_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_DISP = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = in_valid;
                if (in_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                state_next = sts.need_disp ? ST_DISP : ST_FIN;
            end
            ST_DISP: begin
                cmd.disp = 1'b1;
                if (sts.disp_done) state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/pts_dp.sv =====
// Thread tables, ready and mutex queues and dispatch logic.
module pts_dp #(
    parameter int MAX_THREADS = pts_pkg::MAX_THREADS_DEF,
    parameter int NUM_MUTEXES = pts_pkg::NUM_MUTEXES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  pts_pkg::req_t req,
    input  pts_pkg::cmd_t cmd,
    output pts_pkg::sts_t sts,
    output pts_pkg::rsp_t rsp
);
    import pts_pkg::*;

    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam int NW = $clog2(MAX_THREADS + 2);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_THREADS);

    logic [PRIO_W-1:0] prio_mem [MAX_THREADS];
    logic [TW-1:0]     link_mem [MAX_THREADS];
    logic [TW-1:0]     join_mem [MAX_THREADS];
    logic [MW-1:0]     pmtx_mem [MAX_THREADS];
    logic [MAX_THREADS-1:0] in_ready_reg, joiner_v_reg, pend_reg;

    logic [TW-1:0] rhead_reg [NUM_LEVELS];
    logic [TW-1:0] rtail_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] rne_reg;
    logic [NUM_MUTEXES-1:0] busy_reg, lne_reg;
    logic [TW-1:0] lhead_reg [NUM_MUTEXES];
    logic [TW-1:0] ltail_reg [NUM_MUTEXES];

    logic [TW-1:0] cur_reg;
    logic          curv_reg, main_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] iter_reg;
    req_t          req_reg;
    logic          err_reg;
    logic [TW-1:0] newt_reg, was_tid_reg;
    logic          was_v_reg;
    rsp_t          rsp_reg;
    rsp_t          rsp_next;
    logic          err_next, need_next;

    // request decode
    logic          is_main, tgt_ok, mid_ok;
    logic [TW-1:0] tgt, cur_eff;
    logic [MW-1:0] mid;
    logic          curv_eff;

    assign tgt = TW'(req_reg.target_tid);
    assign mid = MW'(req_reg.mutex_id);
    assign tgt_ok = (32'(req_reg.target_tid) < MAX_THREADS);
    assign mid_ok = (32'(req_reg.mutex_id) < NUM_MUTEXES);
    assign is_main = (req_reg.req_type == REQ_CREATE) || (req_reg.req_type == REQ_YIELD)
                  || (req_reg.req_type == REQ_WAIT) || (req_reg.req_type == REQ_LOCK);
    assign curv_eff = curv_reg || (is_main && !main_reg);
    assign cur_eff  = (is_main && !main_reg) ? '0 : cur_reg;

    // push on ready queue / lock queue, one each per cycle
    logic          rpush_en, lpush_en, lpop_en, rpop_en;
    logic [TW-1:0] rpush_t, lpush_t;
    logic [1:0]    rpush_p;
    logic [MW-1:0] lpush_m;

    // dispatch step
    logic [1:0]    dp;
    logic          dany;
    logic [TW-1:0] dt;

    always_comb begin
        dany = |rne_reg;
        dp = 2'd2;
        if (rne_reg[0])      dp = 2'd0;
        else if (rne_reg[1]) dp = 2'd1;
        dt = rhead_reg[dp];
    end

    always_comb begin
        rpush_en = 1'b0; rpush_t = '0; rpush_p = '0;
        lpush_en = 1'b0; lpush_t = '0; lpush_m = '0;
        lpop_en = 1'b0;  rpop_en = 1'b0;
        if (cmd.exec && !err_next) begin
            unique case (req_reg.req_type)
                REQ_CREATE: begin
                    rpush_en = 1'b1; rpush_t = TW'(cnt_reg); rpush_p = req_reg.prio;
                end
                REQ_YIELD: begin
                    rpush_en = 1'b1; rpush_t = cur_eff;
                    rpush_p = (is_main && !main_reg) ? 2'd0 : prio_mem[cur_eff];
                end
                REQ_EXIT: begin
                    if (joiner_v_reg[cur_reg]) begin
                        rpush_en = 1'b1; rpush_t = join_mem[cur_reg];
                        rpush_p = prio_mem[join_mem[cur_reg]];
                    end
                end
                REQ_LOCK: begin
                    if (busy_reg[mid]) begin
                        lpush_en = 1'b1; lpush_t = cur_eff; lpush_m = mid;
                    end
                end
                REQ_UNLOCK: begin
                    if (lne_reg[mid]) begin
                        lpop_en = 1'b1; rpush_en = 1'b1; rpush_t = lhead_reg[mid];
                        rpush_p = prio_mem[lhead_reg[mid]];
                    end
                end
                default: ;
            endcase
        end else if (cmd.disp && dany && iter_reg <= NW'(MAX_THREADS)) begin
            rpop_en = 1'b1;
            if (pend_reg[dt] && busy_reg[pmtx_mem[dt]]) begin
                lpush_en = 1'b1; lpush_t = dt; lpush_m = pmtx_mem[dt];
            end
        end
        if (rpush_p > 2'd2) rpush_p = 2'd2;
    end

    always_comb begin
        err_next = 1'b0;
        need_next = 1'b0;
        unique case (req_reg.req_type)
            REQ_CREATE: err_next = (req_reg.prio > 2'd2) || (cnt_reg >= CNT_MAX);
            REQ_YIELD: begin err_next = !curv_eff; need_next = 1'b1; end
            REQ_WAIT: begin
                err_next = !curv_eff || !tgt_ok || joiner_v_reg[tgt] || !in_ready_reg[tgt];
                need_next = 1'b1;
            end
            REQ_EXIT: begin err_next = !curv_reg; need_next = 1'b1; end
            REQ_MINIT, REQ_UNLOCK: err_next = !mid_ok;
            REQ_LOCK: begin
                err_next = !mid_ok || (busy_reg[mid] && !curv_eff);
                need_next = mid_ok && busy_reg[mid];
            end
            default: err_next = 1'b1;
        endcase
        need_next = need_next && !err_next;
    end

    assign sts.need_disp = need_next;
    assign sts.disp_done = !dany || (iter_reg > NW'(MAX_THREADS))
                        || !(pend_reg[dt] && busy_reg[pmtx_mem[dt]]);

    always_ff @(posedge aclk) begin
        if (rpush_en) begin
            if (rne_reg[rpush_p] && !(rpop_en && dp == rpush_p && rhead_reg[dp] == rtail_reg[dp]))
                link_mem[rtail_reg[rpush_p]] <= rpush_t;
        end
        if (lpush_en && lne_reg[lpush_m] && !(lpop_en && lpush_m == mid))
            link_mem[ltail_reg[lpush_m]] <= lpush_t;
        if (cmd.exec && !err_next) begin
            if (req_reg.req_type == REQ_CREATE) prio_mem[TW'(cnt_reg)] <= req_reg.prio;
            if (is_main && !main_reg) prio_mem[0] <= '0;
            if (req_reg.req_type == REQ_WAIT) join_mem[tgt] <= cur_eff;
            if (req_reg.req_type == REQ_LOCK) pmtx_mem[cur_eff] <= mid;
        end else if (cmd.exec && is_main && !main_reg) begin
            prio_mem[0] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) req_reg <= req;
        if (cmd.finish) rsp_reg <= rsp_next;
        if (cmd.exec) begin
            was_tid_reg <= cur_reg;
            was_v_reg <= curv_reg;
            err_reg <= err_next;
            newt_reg <= (req_reg.req_type == REQ_CREATE && !err_next) ? TW'(cnt_reg) : '0;
        end
    end

    always_comb begin
        rsp_next.status = err_reg;
        rsp_next.new_tid = TID_W'(newt_reg);
        rsp_next.running_tid = curv_reg ? TID_W'(cur_reg) : '0;
        rsp_next.running_valid = curv_reg;
        rsp_next.switched = (was_v_reg != curv_reg) || (curv_reg && was_tid_reg != cur_reg);
    end
    assign rsp = rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ready_reg <= '0; joiner_v_reg <= '0; pend_reg <= '0;
            rne_reg <= '0; busy_reg <= '0; lne_reg <= '0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                rhead_reg[i] <= '0; rtail_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_MUTEXES; i++) begin
                lhead_reg[i] <= '0; ltail_reg[i] <= '0;
            end
            cur_reg <= '0; curv_reg <= 1'b0; main_reg <= 1'b0;
            cnt_reg <= CW'(1); iter_reg <= '0;
        end else begin
            if (cmd.exec) begin
                iter_reg <= '0;
                if (is_main && !main_reg) begin
                    main_reg <= 1'b1; cur_reg <= '0;
                end
                if (!err_next && need_next) curv_reg <= 1'b0;
                else if (is_main && !main_reg) curv_reg <= 1'b1;
                if (!err_next) begin
                    unique case (req_reg.req_type)
                        REQ_CREATE: begin
                            cnt_reg <= cnt_reg + 1'b1;
                            pend_reg[TW'(cnt_reg)] <= 1'b0;
                            joiner_v_reg[TW'(cnt_reg)] <= 1'b0;
                        end
                        REQ_WAIT: joiner_v_reg[tgt] <= 1'b1;
                        REQ_EXIT: joiner_v_reg[cur_reg] <= 1'b0;
                        REQ_MINIT: begin
                            busy_reg[mid] <= 1'b0; lne_reg[mid] <= 1'b0;
                            lhead_reg[mid] <= '0; ltail_reg[mid] <= '0;
                        end
                        REQ_LOCK: begin
                            busy_reg[mid] <= 1'b1;
                            if (busy_reg[mid]) pend_reg[cur_eff] <= 1'b1;
                        end
                        REQ_UNLOCK: busy_reg[mid] <= 1'b0;
                        default: ;
                    endcase
                end
            end
            if (cmd.disp) begin
                iter_reg <= iter_reg + 1'b1;
                if (rpop_en && !lpush_en) begin
                    cur_reg <= dt; curv_reg <= 1'b1;
                    if (pend_reg[dt]) begin
                        busy_reg[pmtx_mem[dt]] <= 1'b1;
                        pend_reg[dt] <= 1'b0;
                    end
                end
            end
            if (lpop_en) begin
                if (lhead_reg[mid] == ltail_reg[mid]) lne_reg[mid] <= 1'b0;
                else lhead_reg[mid] <= link_mem[lhead_reg[mid]];
            end
            if (lpush_en) begin
                if (!lne_reg[lpush_m]) lhead_reg[lpush_m] <= lpush_t;
                ltail_reg[lpush_m] <= lpush_t;
                lne_reg[lpush_m] <= 1'b1;
            end
            if (rpop_en) begin
                in_ready_reg[dt] <= 1'b0;
                if (rhead_reg[dp] == rtail_reg[dp]) rne_reg[dp] <= 1'b0;
                else rhead_reg[dp] <= link_mem[dt];
            end
            if (rpush_en) begin
                if (!rne_reg[rpush_p]) rhead_reg[rpush_p] <= rpush_t;
                rtail_reg[rpush_p] <= rpush_t;
                rne_reg[rpush_p] <= 1'b1;
                in_ready_reg[rpush_t] <= 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/priority_thread_scheduler.sv =====
// Top level of the three-level priority thread scheduler.
// A request is captured from the input, executed, optionally dispatched (repeated while
// lock re-checks apply), then its response is registered and offered on the output.
// One request at a time: the next input is taken the cycle after the result transfer.
// Reset: synchronous active-low aresetn empties all queues, frees all mutexes,
// clears the running thread and sets the next thread id to one.
module priority_thread_scheduler #(
    parameter int MAX_THREADS = pts_pkg::MAX_THREADS_DEF,
    parameter int NUM_MUTEXES = pts_pkg::NUM_MUTEXES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // req_type[2:0], prio[4:3], target_tid[8:5], mutex_id[10:9]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // status[0], new_tid[4:1], running_tid[8:5],
                                  // running_valid[9], switched[10]
);
    import pts_pkg::*;

    req_t req;
    rsp_t rsp;
    cmd_t cmd;
    sts_t sts;

    assign req.req_type   = s_tdata[2:0];
    assign req.prio       = s_tdata[4:3];
    assign req.target_tid = s_tdata[8:5];
    assign req.mutex_id   = s_tdata[10:9];

    assign m_tdata = {5'd0, rsp.switched, rsp.running_valid, rsp.running_tid,
                      rsp.new_tid, rsp.status};

    pts_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd(cmd), .sts(sts)
    );

    pts_dp #(.MAX_THREADS(MAX_THREADS), .NUM_MUTEXES(NUM_MUTEXES)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .req(req), .cmd(cmd), .sts(sts), .rsp(rsp)
    );

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output both open");
    a_new_tid_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[4:1] == 4'd0) else $error("tid on error");
    a_run_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[9] |-> m_tdata[8:5] == 4'd0) else $error("stale running tid");

endmodule
